[hw/rtl/spq_pkg.sv]
package spq_pkg;

    localparam int CAPACITY_DEF      = 16;
    localparam int PRIORITY_BITS_DEF = 8;
    localparam int HANDLE_BITS_DEF   = 16;

    localparam int ID_W  = 16;
    localparam int PRI_W = 8;
    localparam int CNT_W = 5;
    localparam int STS_W = 2;

    localparam logic FUNC_ENQ = 1'b0;
    localparam logic FUNC_DEQ = 1'b1;

    typedef enum logic [STS_W-1:0] {
        ST_ENQ   = 2'd0,
        ST_DEQ   = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } status_code_t;

    typedef struct packed {
        logic capture;
        logic enq;
        logic deq;
        logic load;
    } cmd_t;

    typedef struct packed {
        logic func_deq;
        logic full;
        logic empty;
    } sts_t;

endpackage

[hw/rtl/spq_ctrl.sv]
module spq_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  logic          out_stall,
    input  spq_pkg::sts_t sts,
    output spq_pkg::cmd_t cmd
);
    import spq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;
    logic   in_take;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign in_take   = in_valid && (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    cmd.enq        = !sts.func_deq && !sts.full;
                    cmd.deq        = sts.func_deq && !sts.empty;
                    cmd.load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_take_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == S_EXEC)
        else $error("accepted word did not start execution");

    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> out_valid_reg)
        else $error("result load without output valid");

    a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.enq && cmd.deq))
        else $error("enqueue and dequeue issued together");
`endif

endmodule

[hw/rtl/spq_datapath.sv]
module spq_datapath #(
    parameter int CAPACITY      = spq_pkg::CAPACITY_DEF,
    parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF,
    parameter int HANDLE_BITS   = spq_pkg::HANDLE_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  spq_pkg::cmd_t              cmd,
    output spq_pkg::sts_t              sts,
    input  logic                       func,
    input  logic [spq_pkg::ID_W-1:0]   proc_id,
    input  logic [spq_pkg::PRI_W-1:0]  proc_priority,
    output logic [spq_pkg::STS_W-1:0]  status,
    output logic [spq_pkg::ID_W-1:0]   out_id,
    output logic [spq_pkg::PRI_W-1:0]  out_priority,
    output logic                       is_empty,
    output logic [spq_pkg::CNT_W-1:0]  entry_count
);
    import spq_pkg::*;

    localparam int OCC_W = $clog2(CAPACITY + 1);

    logic                     func_reg;
    logic [HANDLE_BITS-1:0]   hid_reg;
    logic [PRIORITY_BITS-1:0] hpri_reg;
    logic [31:0]              id_ext;
    logic [31:0]              pri_ext;

    logic [HANDLE_BITS-1:0]   id_reg   [CAPACITY];
    logic [PRIORITY_BITS-1:0] pri_reg  [CAPACITY];
    logic [HANDLE_BITS-1:0]   id_next  [CAPACITY];
    logic [PRIORITY_BITS-1:0] pri_next [CAPACITY];
    logic [CAPACITY-1:0]      le;

    logic [OCC_W-1:0]         occ_reg, occ_next;
    logic                     full;
    logic                     empty;

    status_code_t             code;
    logic [31:0]              head_id_ext;
    logic [31:0]              head_pri_ext;
    logic [31:0]              occ_ext;

    logic [STS_W-1:0]         status_reg;
    logic [ID_W-1:0]          out_id_reg;
    logic [PRI_W-1:0]         out_pri_reg;
    logic                     is_empty_reg;
    logic [CNT_W-1:0]         count_reg;

    assign id_ext  = 32'(proc_id);
    assign pri_ext = 32'(proc_priority);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg <= func;
            hid_reg  <= id_ext[HANDLE_BITS-1:0];
            hpri_reg <= pri_ext[PRIORITY_BITS-1:0];
        end
    end

    assign full  = (occ_reg == OCC_W'(CAPACITY));
    assign empty = (occ_reg == '0);

    assign sts.func_deq = (func_reg == FUNC_DEQ);
    assign sts.full     = full;
    assign sts.empty    = empty;

    // sorted cells: on insert keep below the insert point, take new word at it, shift above it; on remove shift down
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [HANDLE_BITS-1:0]   lo_id;
        logic [PRIORITY_BITS-1:0] lo_pri;
        logic                     lo_le;
        logic [HANDLE_BITS-1:0]   hi_id;
        logic [PRIORITY_BITS-1:0] hi_pri;

        assign le[g] = (OCC_W'(g) < occ_reg) && (pri_reg[g] <= hpri_reg);

        if (g == 0)
        begin : g_first
            assign lo_id  = hid_reg;
            assign lo_pri = hpri_reg;
            assign lo_le  = 1'b1;
        end
        else
        begin : g_rest
            assign lo_id  = id_reg[g-1];
            assign lo_pri = pri_reg[g-1];
            assign lo_le  = le[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign hi_id  = id_reg[g];
            assign hi_pri = pri_reg[g];
        end
        else
        begin : g_mid
            assign hi_id  = id_reg[g+1];
            assign hi_pri = pri_reg[g+1];
        end

        assign id_next[g]  = cmd.deq ? hi_id  :
                             le[g]   ? id_reg[g]  :
                             lo_le   ? hid_reg    : lo_id;
        assign pri_next[g] = cmd.deq ? hi_pri :
                             le[g]   ? pri_reg[g] :
                             lo_le   ? hpri_reg   : lo_pri;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.enq || cmd.deq)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                id_reg[i]  <= id_next[i];
                pri_reg[i] <= pri_next[i];
            end
        end
    end

    always_comb
    begin
        occ_next = occ_reg;
        if (cmd.enq)
        begin
            occ_next = occ_reg + OCC_W'(1);
        end
        else if (cmd.deq)
        begin
            occ_next = occ_reg - OCC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_comb
    begin
        if (func_reg == FUNC_DEQ)
        begin
            code = empty ? ST_EMPTY : ST_DEQ;
        end
        else
        begin
            code = full ? ST_FULL : ST_ENQ;
        end
    end

    assign head_id_ext  = 32'(id_reg[0]);
    assign head_pri_ext = 32'(pri_reg[0]);
    assign occ_ext      = 32'(occ_next);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            status_reg   <= code;
            out_id_reg   <= cmd.deq ? head_id_ext[ID_W-1:0]   : '0;
            out_pri_reg  <= cmd.deq ? head_pri_ext[PRI_W-1:0] : '0;
            is_empty_reg <= (occ_next == '0);
            count_reg    <= occ_ext[CNT_W-1:0];
        end
    end

    assign status       = status_reg;
    assign out_id       = out_id_reg;
    assign out_priority = out_pri_reg;
    assign is_empty     = is_empty_reg;
    assign entry_count  = count_reg;

`ifndef SYNTHESIS
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(CAPACITY))
        else $error("occupancy above capacity");

    a_enq_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.enq |=> occ_reg == $past(occ_reg) + OCC_W'(1))
        else $error("enqueue did not grow the queue by one");

    a_deq_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.deq |=> occ_reg == $past(occ_reg) - OCC_W'(1))
        else $error("dequeue did not shrink the queue by one");

    a_head_order: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg >= OCC_W'(2) |-> pri_reg[0] <= pri_reg[1])
        else $error("head entries out of priority order");
`endif

endmodule

[hw/rtl/stable_priority_ready_queue_unit.sv]
// An accepted input word is captured and then executed; its result word is loaded
// into the output register once that register is free.
// The controller takes a new word only after the previous one has executed, and
// execution waits on a held result.
// Insert and remove run across the row of compare-and-shift cells.
// Reset (rst_n, async, active low) empties the queue; slot contents are not cleared.
module stable_priority_ready_queue_unit #(
    parameter int CAPACITY      = spq_pkg::CAPACITY_DEF,
    parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF,
    parameter int HANDLE_BITS   = spq_pkg::HANDLE_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       func,
    input  logic [spq_pkg::ID_W-1:0]   proc_id,
    input  logic [spq_pkg::PRI_W-1:0]  proc_priority,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [spq_pkg::STS_W-1:0]  status,
    output logic [spq_pkg::ID_W-1:0]   out_id,
    output logic [spq_pkg::PRI_W-1:0]  out_priority,
    output logic                       is_empty,
    output logic [spq_pkg::CNT_W-1:0]  entry_count
);
    import spq_pkg::*;

    cmd_t cmd;
    sts_t sts;

    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    spq_datapath #(
        .CAPACITY      (CAPACITY),
        .PRIORITY_BITS (PRIORITY_BITS),
        .HANDLE_BITS   (HANDLE_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .func          (func),
        .proc_id       (proc_id),
        .proc_priority (proc_priority),
        .status        (status),
        .out_id        (out_id),
        .out_priority  (out_priority),
        .is_empty      (is_empty),
        .entry_count   (entry_count)
    );

endmodule

[tb/tb_stable_priority_ready_queue_unit.sv]
module tb_stable_priority_ready_queue_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam int QCAP        = CAPACITY_DEF;
    localparam int N_RANDOM    = 400;
    localparam int LONG_HOLD   = 80;
    localparam int IDLE_LIMIT  = 4000;
    localparam int N_DIR       = 23;

    typedef struct packed {
        status_code_t         st;
        logic [ID_W-1:0]      oid;
        logic [PRI_W-1:0]     opri;
        logic                 emp;
        logic [CNT_W-1:0]     cnt;
    } qres_t;

    typedef struct packed {
        logic                 f;
        logic [ID_W-1:0]      id;
        logic [PRI_W-1:0]     pri;
        logic                 typed;
        qres_t                res;
    } dir_row_t;

    localparam qres_t NO_RES = '{ST_ENQ, '0, '0, 1'b0, '0};

    localparam dir_row_t DIR_ROWS [N_DIR] = '{
        '{FUNC_DEQ, 16'h1234, 8'h56, 1'b1, '{ST_EMPTY, 16'h0000, 8'h00, 1'b1, 5'd0}},
        '{FUNC_ENQ, 16'hFFFF, 8'hFF, 1'b1, '{ST_ENQ, 16'h0000, 8'h00, 1'b0, 5'd1}},
        '{FUNC_ENQ, 16'h0000, 8'h00, 1'b1, '{ST_ENQ, 16'h0000, 8'h00, 1'b0, 5'd2}},
        '{FUNC_ENQ, 16'h0001, 8'h00, 1'b0, NO_RES},
        '{FUNC_ENQ, 16'h8000, 8'h80, 1'b0, NO_RES},
        '{FUNC_ENQ, 16'h7FFF, 8'h7F, 1'b0, NO_RES},
        '{FUNC_ENQ, 16'hAAAA, 8'hFF, 1'b0, NO_RES},
        '{FUNC_ENQ, 16'h5555, 8'h55, 1'b0, NO_RES},
        '{FUNC_ENQ, 16'h1234, 8'h80, 1'b0, NO_RES},
        '{FUNC_ENQ, 16'h0100, 8'h01, 1'b0, NO_RES},
        '{FUNC_ENQ, 16'h0101, 8'hFE, 1'b0, NO_RES},
        '{FUNC_ENQ, 16'h0102, 8'h7F, 1'b0, NO_RES},
        '{FUNC_ENQ, 16'h0103, 8'h80, 1'b0, NO_RES},
        '{FUNC_ENQ, 16'h0104, 8'h00, 1'b0, NO_RES},
        '{FUNC_ENQ, 16'h0105, 8'hAA, 1'b0, NO_RES},
        '{FUNC_ENQ, 16'h0106, 8'h55, 1'b0, NO_RES},
        '{FUNC_ENQ, 16'h0F0F, 8'h3C, 1'b0, NO_RES},
        '{FUNC_ENQ, 16'h0BAD, 8'h00, 1'b1, '{ST_FULL, 16'h0000, 8'h00, 1'b0, 5'd16}},
        '{FUNC_DEQ, 16'hFFFF, 8'hFF, 1'b1, '{ST_DEQ, 16'h0000, 8'h00, 1'b0, 5'd15}},
        '{FUNC_DEQ, 16'h0000, 8'h00, 1'b0, NO_RES},
        '{FUNC_DEQ, 16'h5A5A, 8'hA5, 1'b0, NO_RES},
        '{FUNC_DEQ, 16'h0000, 8'h00, 1'b0, NO_RES},
        '{FUNC_DEQ, 16'h0000, 8'h00, 1'b0, NO_RES}
    };

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid;
    logic               in_stall;
    logic               func;
    logic [ID_W-1:0]    proc_id;
    logic [PRI_W-1:0]   proc_priority;
    logic               out_valid;
    logic               out_stall;
    logic [STS_W-1:0]   status;
    logic [ID_W-1:0]    out_id;
    logic [PRI_W-1:0]   out_priority;
    logic               is_empty;
    logic [CNT_W-1:0]   entry_count;

    logic [ID_W-1:0]    model_ids [QCAP];
    logic [PRI_W-1:0]   model_pris [QCAP];
    int                 model_len = 0;

    qres_t              pending_results [$];
    int                 err_count = 0;
    int                 idle_cycles = 0;
    bit                 hold_req = 1'b0;

    stable_priority_ready_queue_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .proc_id       (proc_id),
        .proc_priority (proc_priority),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .out_id        (out_id),
        .out_priority  (out_priority),
        .is_empty      (is_empty),
        .entry_count   (entry_count)
    );

    always #1 clk = ~clk;

    function automatic qres_t ready_queue_step(input logic f, input logic [ID_W-1:0] id,
                                               input logic [PRI_W-1:0] pri);
        qres_t r;
        int pos;
        int i;
        r = NO_RES;
        if (f == FUNC_ENQ) begin
            if (model_len >= QCAP) begin
                r.st = ST_FULL;
            end
            else begin
                pos = 0;
                while (pos < model_len && model_pris[pos] <= pri)
                    pos++;
                for (i = model_len; i > pos; i--)
                begin
                    model_ids[i]  = model_ids[i-1];
                    model_pris[i] = model_pris[i-1];
                end
                model_ids[pos]  = id;
                model_pris[pos] = pri;
                model_len++;
                r.st = ST_ENQ;
            end
        end
        else begin
            if (model_len == 0) begin
                r.st = ST_EMPTY;
            end
            else begin
                r.oid  = model_ids[0];
                r.opri = model_pris[0];
                for (i = 1; i < model_len; i++)
                begin
                    model_ids[i-1]  = model_ids[i];
                    model_pris[i-1] = model_pris[i];
                end
                model_len--;
                r.st = ST_DEQ;
            end
        end
        r.emp = (model_len == 0);
        r.cnt = CNT_W'(model_len);
        return r;
    endfunction

    task automatic send_word(input logic f, input logic [ID_W-1:0] id,
                             input logic [PRI_W-1:0] pri, input logic typed, input qres_t fixed);
        qres_t pred;
        in_valid      <= 1'b1;
        func          <= f;
        proc_id       <= id;
        proc_priority <= pri;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pred = ready_queue_step(f, id, pri);
        pending_results.push_back(typed ? fixed : pred);
    endtask

    // result checker
    always @(posedge clk)
    begin
        qres_t got;
        qres_t want;
        if (rst_n && out_valid && !out_stall) begin
            got.st   = status_code_t'(status);
            got.oid  = out_id;
            got.opri = out_priority;
            got.emp  = is_empty;
            got.cnt  = entry_count;
            if (pending_results.size() == 0) begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected word: st=%0d id=%h pri=%h emp=%b cnt=%0d",
                             got.st, got.oid, got.opri, got.emp, got.cnt);
            end
            else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("mismatch: exp st=%0d id=%h pri=%h emp=%b cnt=%0d, got st=%0d id=%h pri=%h emp=%b cnt=%0d",
                                 want.st, want.oid, want.opri, want.emp, want.cnt,
                                 got.st, got.oid, got.opri, got.emp, got.cnt);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        int span;
        int pct;
        span = 0;
        pct  = 0;
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD - 1) @(posedge clk);
            end
            else begin
                if (span == 0) begin
                    case ($urandom_range(0, 3))
                        0: pct = 0;
                        1: pct = 30;
                        2: pct = 60;
                        default: pct = 85;
                    endcase
                    span = $urandom_range(10, 60);
                end
                span--;
                out_stall <= ($urandom_range(0, 99) < pct);
            end
        end
    end

    initial
    begin
        int i;
        int gap;
        int burst_left;
        int enq_pct;
        logic f;
        logic [ID_W-1:0] id;
        logic [PRI_W-1:0] pri;

        in_valid      <= 1'b0;
        func          <= FUNC_ENQ;
        proc_id       <= '0;
        proc_priority <= '0;
        burst_left    = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < N_DIR; i++)
            send_word(DIR_ROWS[i].f, DIR_ROWS[i].id, DIR_ROWS[i].pri,
                      DIR_ROWS[i].typed, DIR_ROWS[i].res);

        for (i = 0; i < N_RANDOM; i++)
        begin
            case ((i / 40) % 4)
                0: enq_pct = 85;
                1: enq_pct = 50;
                2: enq_pct = 20;
                default: enq_pct = 55;
            endcase
            if (i == 120)
                hold_req = 1'b1;
            if (i == 260) begin
                // drain everything before continuing
                in_valid <= 1'b0;
                while (pending_results.size() != 0)
                    @(posedge clk);
                burst_left = 0;
            end
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap != 0) begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
            f  = ($urandom_range(0, 99) < enq_pct) ? FUNC_ENQ : FUNC_DEQ;
            id = ID_W'($urandom());
            case ($urandom_range(0, 3))
                0: pri = PRI_W'($urandom());
                1: pri = PRI_W'($urandom_range(0, 3));
                2: pri = PRI_W'($urandom_range(252, 255));
                default: pri = PRI_W'($urandom_range(0, 255));
            endcase
            send_word(f, id, pri, 1'b0, NO_RES);
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (err_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

[stable_priority_ready_queue_unit.f]
hw/rtl/spq_pkg.sv
hw/rtl/spq_ctrl.sv
hw/rtl/spq_datapath.sv
hw/rtl/stable_priority_ready_queue_unit.sv
tb/tb_stable_priority_ready_queue_unit.sv
